@@ sv/cmtr_pkg.sv @@
// ----------------------------------------------------------------------------
// cmtr_pkg: shared types and constants of the channel statistics tracker
// Field widths, item classification codes and the queue geometry.
// ----------------------------------------------------------------------------
`default_nettype none

package cmtr_pkg;

    localparam int CHAN_W   = 4;
    localparam int SAMPLE_W = 12;
    localparam int TS_W     = 32;
    localparam int CNT_W    = 16;
    localparam int SUM_W    = SAMPLE_W + CNT_W;
    localparam int REM_W    = CNT_W + 1;
    localparam int STEP_W   = 4;

    localparam logic [CNT_W-1:0] WINDOW_RESET = 16'd16;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    typedef enum logic [1:0] {
        KIND_SAMPLE = 2'd0,
        KIND_CLEAR  = 2'd1,
        KIND_BAD    = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind                kind;
        logic [CHAN_W-1:0]    channel;
        logic [SAMPLE_W-1:0]  sample;
        logic [TS_W-1:0]      timestamp;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    typedef struct packed {
        logic [CHAN_W-1:0]    out_channel;
        logic [SAMPLE_W-1:0]  min_value;
        logic [SAMPLE_W-1:0]  max_value;
        logic [SAMPLE_W-1:0]  avg_value;
        logic [TS_W-1:0]      min_time;
        logic [TS_W-1:0]      max_time;
        logic [CNT_W-1:0]     sample_count;
        logic                 stats_valid;
        logic                 bad_channel;
    } t_result;

endpackage

`default_nettype wire

@@ sv/cmtr_front.sv @@
// ----------------------------------------------------------------------------
// cmtr_front: request intake and classification
// Registers each request, tags it as sample, clear or bad channel, and
// hands it to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module cmtr_front #(
    parameter int NUM_CHANNELS = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic                            i_command,
    input  logic [cmtr_pkg::CHAN_W-1:0]     i_channel,
    input  logic [cmtr_pkg::SAMPLE_W-1:0]   i_sample,
    input  logic [cmtr_pkg::TS_W-1:0]       i_timestamp,
    input  cmtr_pkg::t_qstat                i_qstat,
    output logic                            o_push,
    output cmtr_pkg::t_item                 o_item
);
    import cmtr_pkg::*;

    logic  r_valid, n_valid;
    t_item r_item,  n_item;
    logic  accept;
    logic  bad;

    assign bad     = ({1'b0, i_channel} >= (CHAN_W + 1)'(NUM_CHANNELS));
    assign o_stall = r_valid && i_qstat.full;
    assign accept  = i_valid && !o_stall;
    assign o_push  = r_valid && !i_qstat.full;
    assign o_item  = r_item;

    always_comb begin
        n_valid = r_valid;
        n_item  = r_item;
        if (o_push) begin
            n_valid = 1'b0;
        end
        if (accept) begin
            n_valid          = 1'b1;
            n_item.channel   = i_channel;
            n_item.sample    = i_sample;
            n_item.timestamp = i_timestamp;
            if (bad) begin
                n_item.kind = KIND_BAD;
            end else if (i_command == CMD_CLEAR) begin
                n_item.kind = KIND_CLEAR;
            end else begin
                n_item.kind = KIND_SAMPLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_item <= n_item;
    end

endmodule

`default_nettype wire

@@ sv/cmtr_fifo.sv @@
// ----------------------------------------------------------------------------
// cmtr_fifo: short request queue
// Decouples intake from the arithmetic back end.
// ----------------------------------------------------------------------------
`default_nettype none

module cmtr_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  cmtr_pkg::t_item  i_item,
    input  logic             i_pop,
    output cmtr_pkg::t_item  o_item,
    output cmtr_pkg::t_qstat o_qstat
);
    import cmtr_pkg::*;

    t_item              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wp, n_wp;
    logic [QPTR_W-1:0]  r_rp, n_rp;
    logic [QCNT_W-1:0]  r_cnt, n_cnt;

    assign o_item        = r_mem[r_rp];
    assign o_qstat.full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_qstat.empty = (r_cnt == '0);

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = (r_wp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (i_pop) begin
            n_rp = (r_rp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

`default_nettype wire

@@ sv/cmtr_back.sv @@
// ----------------------------------------------------------------------------
// cmtr_back: statistics engine
// Holds the per-channel store, updates min, max and the cumulative average
// with a multiply and a restoring divider, and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cmtr_back #(
    parameter int NUM_CHANNELS = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  cmtr_pkg::t_qstat             i_qstat,
    input  cmtr_pkg::t_item              i_item,
    output logic                         o_pop,
    input  logic                         i_cfg_valid,
    input  logic [cmtr_pkg::CNT_W-1:0]   i_cfg_data,
    input  logic                         i_stall,
    output logic                         o_valid,
    output cmtr_pkg::t_result            o_result
);
    import cmtr_pkg::*;

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_READ = 6'b000010,
        S_MUL  = 6'b000100,
        S_DIV  = 6'b001000,
        S_UPD  = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    // Per-channel store; a clear channel reads as zero through its seen flag.
    logic [SAMPLE_W-1:0]     r_min_mem  [NUM_CHANNELS];
    logic [SAMPLE_W-1:0]     r_max_mem  [NUM_CHANNELS];
    logic [SAMPLE_W-1:0]     r_avg_mem  [NUM_CHANNELS];
    logic [CNT_W-1:0]        r_cnt_mem  [NUM_CHANNELS];
    logic [TS_W-1:0]         r_mint_mem [NUM_CHANNELS];
    logic [TS_W-1:0]         r_maxt_mem [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] r_seen_v;

    t_state               r_state,  n_state;
    t_item                r_item,   n_item;
    logic [CNT_W-1:0]     r_window, n_window;
    logic [SAMPLE_W-1:0]  r_min,  n_min;
    logic [SAMPLE_W-1:0]  r_max,  n_max;
    logic [SAMPLE_W-1:0]  r_avg,  n_avg;
    logic [CNT_W-1:0]     r_cnt,  n_cnt;
    logic [TS_W-1:0]      r_mint, n_mint;
    logic [TS_W-1:0]      r_maxt, n_maxt;
    logic                 r_seen, n_seen;
    logic [REM_W-1:0]     r_rem,  n_rem;
    logic [SAMPLE_W-1:0]  r_quo,  n_quo;
    logic [REM_W-1:0]     r_div,  n_div;
    logic [STEP_W-1:0]    r_step, n_step;
    logic                 r_out_valid, n_out_valid;
    t_result              r_result,    n_result;

    logic [IDX_W-1:0]     idx;
    logic [SUM_W-1:0]     prod;
    logic [SUM_W-1:0]     sum;
    logic [REM_W:0]       trial;
    logic                 wr_stats;
    logic                 clr_seen;
    logic                 load_out;

    assign idx      = r_item.channel[IDX_W-1:0];
    assign prod     = SUM_W'(r_avg) * SUM_W'(r_cnt);
    assign sum      = prod + SUM_W'(r_item.sample);
    assign trial    = {r_rem, r_quo[SAMPLE_W-1]} - {1'b0, r_div};
    assign o_valid  = r_out_valid;
    assign o_result = r_result;

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_min       = r_min;
        n_max       = r_max;
        n_avg       = r_avg;
        n_cnt       = r_cnt;
        n_mint      = r_mint;
        n_maxt      = r_maxt;
        n_seen      = r_seen;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_div       = r_div;
        n_step      = r_step;
        n_result    = r_result;
        o_pop       = 1'b0;
        wr_stats    = 1'b0;
        clr_seen    = 1'b0;
        load_out    = 1'b0;
        n_window    = i_cfg_valid ? i_cfg_data : r_window;

        unique case (r_state)
            S_IDLE: begin
                if (!i_qstat.empty) begin
                    o_pop   = 1'b1;
                    n_item  = i_item;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_seen = r_seen_v[idx];
                n_min  = r_seen_v[idx] ? r_min_mem[idx]  : '0;
                n_max  = r_seen_v[idx] ? r_max_mem[idx]  : '0;
                n_avg  = r_seen_v[idx] ? r_avg_mem[idx]  : '0;
                n_cnt  = r_seen_v[idx] ? r_cnt_mem[idx]  : '0;
                n_mint = r_seen_v[idx] ? r_mint_mem[idx] : '0;
                n_maxt = r_seen_v[idx] ? r_maxt_mem[idx] : '0;
                if (r_item.kind == KIND_SAMPLE) begin
                    n_state = S_MUL;
                end else begin
                    clr_seen = (r_item.kind == KIND_CLEAR);
                    n_state  = S_DONE;
                end
            end
            S_MUL: begin
                // The quotient always fits the sample width, so the upper
                // part of the sum already lies below the divisor.
                n_rem   = {1'b0, sum[SUM_W-1:SAMPLE_W]};
                n_quo   = sum[SAMPLE_W-1:0];
                n_div   = {1'b0, r_cnt} + 1'b1;
                n_step  = STEP_W'(SAMPLE_W - 1);
                n_state = S_DIV;
            end
            S_DIV: begin
                if (!trial[REM_W]) begin
                    n_rem = trial[REM_W-1:0];
                end else begin
                    n_rem = {r_rem[REM_W-2:0], r_quo[SAMPLE_W-1]};
                end
                n_quo  = {r_quo[SAMPLE_W-2:0], !trial[REM_W]};
                n_step = r_step - 1'b1;
                if (r_step == '0) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                if (!r_seen || (r_item.sample < r_min)) begin
                    n_min  = r_item.sample;
                    n_mint = r_item.timestamp;
                end
                if (!r_seen || (r_item.sample > r_max)) begin
                    n_max  = r_item.sample;
                    n_maxt = r_item.timestamp;
                end
                n_avg    = r_quo;
                n_cnt    = (r_cnt < r_window) ? r_cnt + 1'b1 : r_cnt;
                n_seen   = 1'b1;
                wr_stats = 1'b1;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (load_out) begin
            n_result             = '0;
            n_result.out_channel = r_item.channel;
            n_result.bad_channel = (r_item.kind == KIND_BAD);
            if (r_item.kind == KIND_SAMPLE) begin
                n_result.min_value    = r_min;
                n_result.max_value    = r_max;
                n_result.avg_value    = r_avg;
                n_result.min_time     = r_mint;
                n_result.max_time     = r_maxt;
                n_result.sample_count = r_cnt;
                n_result.stats_valid  = 1'b1;
            end
        end

        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_window    <= WINDOW_RESET;
            r_out_valid <= 1'b0;
            r_seen_v    <= '0;
        end else begin
            r_state     <= n_state;
            r_window    <= n_window;
            r_out_valid <= n_out_valid;
            if (wr_stats) begin
                r_seen_v[idx] <= 1'b1;
            end else if (clr_seen) begin
                r_seen_v[idx] <= 1'b0;
            end
        end
        r_item   <= n_item;
        r_min    <= n_min;
        r_max    <= n_max;
        r_avg    <= n_avg;
        r_cnt    <= n_cnt;
        r_mint   <= n_mint;
        r_maxt   <= n_maxt;
        r_seen   <= n_seen;
        r_rem    <= n_rem;
        r_quo    <= n_quo;
        r_div    <= n_div;
        r_step   <= n_step;
        r_result <= n_result;
        if (wr_stats) begin
            r_min_mem[idx]  <= n_min;
            r_max_mem[idx]  <= n_max;
            r_avg_mem[idx]  <= n_avg;
            r_cnt_mem[idx]  <= n_cnt;
            r_mint_mem[idx] <= n_mint;
            r_maxt_mem[idx] <= n_maxt;
        end
    end

endmodule

`default_nettype wire

@@ sv/channel_min_max_average_tracker.sv @@
// ----------------------------------------------------------------------------
// channel_min_max_average_tracker: per-channel converter statistics
// Minimum, maximum with timestamps and a window-limited running average.
// ----------------------------------------------------------------------------
// A sample request pops the queue, reads the channel, multiplies, runs twelve
// steps of the restoring divider that forms (avg*n + x) / (n + 1), writes back
// and loads the result register; clear and bad-channel requests pop, read and
// load the result register. Requests are taken into a two-entry queue while
// the engine works, and a finished result waits in its own register, so neither
// side stalls the other until the queue fills. Reset clears every channel at
// once. The window register is written through its own always-ready port; the
// user writes it only while the block is idle; the block does not enforce it.
`default_nettype none

module channel_min_max_average_tracker #(
    parameter int NUM_CHANNELS = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic                            i_command,
    input  logic [cmtr_pkg::CHAN_W-1:0]     i_channel,
    input  logic [cmtr_pkg::SAMPLE_W-1:0]   i_sample,
    input  logic [cmtr_pkg::TS_W-1:0]       i_timestamp,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [cmtr_pkg::CHAN_W-1:0]     o_out_channel,
    output logic [cmtr_pkg::SAMPLE_W-1:0]   o_min_value,
    output logic [cmtr_pkg::SAMPLE_W-1:0]   o_max_value,
    output logic [cmtr_pkg::SAMPLE_W-1:0]   o_avg_value,
    output logic [cmtr_pkg::TS_W-1:0]       o_min_time,
    output logic [cmtr_pkg::TS_W-1:0]       o_max_time,
    output logic [cmtr_pkg::CNT_W-1:0]      o_sample_count,
    output logic                            o_stats_valid,
    output logic                            o_bad_channel,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [cmtr_pkg::CNT_W-1:0]      i_cfg_data
);
    import cmtr_pkg::*;

    t_item   front_item;
    t_item   queue_item;
    t_qstat  qstat;
    logic    push;
    logic    pop;
    t_result result;

    assign o_cfg_ready = 1'b1;

    cmtr_front #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_command   (i_command),
        .i_channel   (i_channel),
        .i_sample    (i_sample),
        .i_timestamp (i_timestamp),
        .i_qstat     (qstat),
        .o_push      (push),
        .o_item      (front_item)
    );

    cmtr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_item  (queue_item),
        .o_qstat (qstat)
    );

    cmtr_back #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_qstat     (qstat),
        .i_item      (queue_item),
        .o_pop       (pop),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_result    (result)
    );

    assign o_out_channel  = result.out_channel;
    assign o_min_value    = result.min_value;
    assign o_max_value    = result.max_value;
    assign o_avg_value    = result.avg_value;
    assign o_min_time     = result.min_time;
    assign o_max_time     = result.max_time;
    assign o_sample_count = result.sample_count;
    assign o_stats_valid  = result.stats_valid;
    assign o_bad_channel  = result.bad_channel;

endmodule

`default_nettype wire

@@ sv/cmtr_checker.sv @@
// ----------------------------------------------------------------------------
// cmtr_checker: port-level checks of the statistics tracker
// Watches the result channel over time and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cmtr_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic                            o_stall,
    input  logic                            i_command,
    input  logic [cmtr_pkg::CHAN_W-1:0]     i_channel,
    input  logic [cmtr_pkg::SAMPLE_W-1:0]   i_sample,
    input  logic [cmtr_pkg::TS_W-1:0]       i_timestamp,
    input  logic                            o_valid,
    input  logic                            i_stall,
    input  logic [cmtr_pkg::CHAN_W-1:0]     o_out_channel,
    input  logic [cmtr_pkg::SAMPLE_W-1:0]   o_min_value,
    input  logic [cmtr_pkg::SAMPLE_W-1:0]   o_max_value,
    input  logic [cmtr_pkg::SAMPLE_W-1:0]   o_avg_value,
    input  logic [cmtr_pkg::TS_W-1:0]       o_min_time,
    input  logic [cmtr_pkg::TS_W-1:0]       o_max_time,
    input  logic [cmtr_pkg::CNT_W-1:0]      o_sample_count,
    input  logic                            o_stats_valid,
    input  logic                            o_bad_channel,
    input  logic                            i_cfg_valid,
    input  logic                            o_cfg_ready,
    input  logic [cmtr_pkg::CNT_W-1:0]      i_cfg_data
);

    // A stalled result stays offered.
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result request dropped while stalled");

    // A stalled result keeps its statistics.
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_avg_value) && $stable(o_min_value)
            && $stable(o_max_value) && $stable(o_sample_count))
        else $error("result payload changed while stalled");

    // An empty or rejected channel reports nothing but its index and flags.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_stats_valid |-> o_min_value == '0 && o_max_value == '0
            && o_avg_value == '0 && o_min_time == '0 && o_max_time == '0
            && o_sample_count == '0)
        else $error("empty channel reported nonzero statistics");

    // The average is a blend of the samples seen, so it sits between them.
    a_avg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_stats_valid |-> !o_bad_channel && o_min_value <= o_avg_value
            && o_avg_value <= o_max_value)
        else $error("average outside the minimum to maximum range");

endmodule

bind channel_min_max_average_tracker cmtr_checker u_cmtr_checker (.*);

`default_nettype wire

@@ tb/sv/tb_channel_min_max_average_tracker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_channel_min_max_average_tracker: self-checking bench for the tracker
// Drives sample, clear and out-of-range requests with random idling and
// output back-pressure. A local copy of the per-channel statistics predicts
// every result, and the results are compared field by field in order.
// ----------------------------------------------------------------------------

module tb_channel_min_max_average_tracker;
    import cmtr_pkg::*;

    localparam int NUM_CHANNELS = 4;
    localparam int HOLD_CYCLES  = 300;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic                 i_command = CMD_SAMPLE;
    logic [CHAN_W-1:0]    i_channel = '0;
    logic [SAMPLE_W-1:0]  i_sample = '0;
    logic [TS_W-1:0]      i_timestamp = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic [CHAN_W-1:0]    o_out_channel;
    logic [SAMPLE_W-1:0]  o_min_value;
    logic [SAMPLE_W-1:0]  o_max_value;
    logic [SAMPLE_W-1:0]  o_avg_value;
    logic [TS_W-1:0]      o_min_time;
    logic [TS_W-1:0]      o_max_time;
    logic [CNT_W-1:0]     o_sample_count;
    logic                 o_stats_valid;
    logic                 o_bad_channel;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CNT_W-1:0]     i_cfg_data = '0;

    // Predicted per-channel statistics and the window register.
    logic [SAMPLE_W-1:0]  ch_min    [NUM_CHANNELS];
    logic [SAMPLE_W-1:0]  ch_max    [NUM_CHANNELS];
    logic [SAMPLE_W-1:0]  ch_avg    [NUM_CHANNELS];
    logic [CNT_W-1:0]     ch_count  [NUM_CHANNELS];
    logic [TS_W-1:0]      ch_min_ts [NUM_CHANNELS];
    logic [TS_W-1:0]      ch_max_ts [NUM_CHANNELS];
    logic                 ch_seen   [NUM_CHANNELS];
    logic [CNT_W-1:0]     avg_window;

    t_result expected_stats[$];
    int      errors = 0;
    bit      no_idle = 1'b0;
    int      rx_hold_request = 0;
    int      rx_hold_left = 0;

    channel_min_max_average_tracker #(
        .NUM_CHANNELS(NUM_CHANNELS)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_command      (i_command),
        .i_channel      (i_channel),
        .i_sample       (i_sample),
        .i_timestamp    (i_timestamp),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_channel  (o_out_channel),
        .o_min_value    (o_min_value),
        .o_max_value    (o_max_value),
        .o_avg_value    (o_avg_value),
        .o_min_time     (o_min_time),
        .o_max_time     (o_max_time),
        .o_sample_count (o_sample_count),
        .o_stats_valid  (o_stats_valid),
        .o_bad_channel  (o_bad_channel),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void clear_channel(int ch);
        ch_min[ch]    = '0;
        ch_max[ch]    = '0;
        ch_avg[ch]    = '0;
        ch_count[ch]  = '0;
        ch_min_ts[ch] = '0;
        ch_max_ts[ch] = '0;
        ch_seen[ch]   = 1'b0;
    endfunction

    // Applies one request to the predicted statistics and returns the result
    // that the block should report for it.
    function automatic t_result update_channel(logic cmd, logic [CHAN_W-1:0] ch,
                                               logic [SAMPLE_W-1:0] smp,
                                               logic [TS_W-1:0] ts);
        t_result     res;
        logic [31:0] n;
        logic [31:0] acc;
        res = '0;
        res.out_channel = ch;
        if (ch >= NUM_CHANNELS) begin
            res.bad_channel = 1'b1;
            return res;
        end
        if (cmd == CMD_CLEAR) begin
            clear_channel(ch);
        end else begin
            n = 32'(ch_count[ch]);
            if (!ch_seen[ch] || smp < ch_min[ch]) begin
                ch_min[ch]    = smp;
                ch_min_ts[ch] = ts;
            end
            if (!ch_seen[ch] || smp > ch_max[ch]) begin
                ch_max[ch]    = smp;
                ch_max_ts[ch] = ts;
            end
            acc = 32'(ch_avg[ch]) * n + 32'(smp);
            ch_avg[ch] = SAMPLE_W'(acc / (n + 32'd1));
            if (ch_count[ch] < avg_window) begin
                ch_count[ch] = ch_count[ch] + 1'b1;
            end
            ch_seen[ch] = 1'b1;
        end
        res.min_value    = ch_min[ch];
        res.max_value    = ch_max[ch];
        res.avg_value    = ch_avg[ch];
        res.min_time     = ch_min_ts[ch];
        res.max_time     = ch_max_ts[ch];
        res.sample_count = ch_count[ch];
        res.stats_valid  = ch_seen[ch];
        return res;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    // Result checker: every accepted result is matched against the oldest
    // prediction.
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_stats.size() == 0) begin
                $error("result for channel %0d arrived with no request pending",
                       o_out_channel);
                errors++;
            end else begin
                want = expected_stats.pop_front();
                check_field("out_channel", want.out_channel, o_out_channel);
                check_field("min_value", want.min_value, o_min_value);
                check_field("max_value", want.max_value, o_max_value);
                check_field("avg_value", want.avg_value, o_avg_value);
                check_field("min_time", want.min_time, o_min_time);
                check_field("max_time", want.max_time, o_max_time);
                check_field("sample_count", want.sample_count, o_sample_count);
                check_field("stats_valid", want.stats_valid, o_stats_valid);
                check_field("bad_channel", want.bad_channel, o_bad_channel);
            end
        end
    end

    // Result side: random stalls, or a long hold-off when one is requested.
    always @(negedge i_clk) begin
        if (rx_hold_request > 0) begin
            rx_hold_left    = rx_hold_request;
            rx_hold_request = 0;
        end
        if (rx_hold_left > 0) begin
            i_stall = 1'b1;
            rx_hold_left--;
        end else begin
            i_stall = !no_idle && ($urandom_range(99) < 6);
        end
    end

    // Called and returning just after a falling edge. Valid stays high from
    // one request to the next unless an idle gap is rolled.
    task automatic send_request(logic cmd, logic [CHAN_W-1:0] ch,
                                logic [SAMPLE_W-1:0] smp, logic [TS_W-1:0] ts);
        while (!no_idle && $urandom_range(99) < 6) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid     = 1'b1;
        i_command   = cmd;
        i_channel   = ch;
        i_sample    = smp;
        i_timestamp = ts;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        expected_stats.push_back(update_channel(cmd, ch, smp, ts));
        @(negedge i_clk);
    endtask

    task automatic wait_drained;
        i_valid = 1'b0;
        while (expected_stats.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic write_window(logic [CNT_W-1:0] value);
        wait_drained();
        i_cfg_valid = 1'b1;
        i_cfg_data  = value;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        avg_window = value;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Empty channels read as all zero; out-of-range channels change nothing.
    task automatic test_empty_and_bad_channels;
        send_request(CMD_CLEAR, 4'd0, 12'd0, 32'd0);
        send_request(CMD_CLEAR, 4'd3, 12'hFFF, 32'hFFFF_FFFF);
        send_request(CMD_SAMPLE, 4'd4, 12'hFFF, 32'hFFFF_FFFF);
        send_request(CMD_SAMPLE, 4'd15, 12'd0, 32'd0);
        send_request(CMD_CLEAR, 4'd9, 12'hA5A, 32'h5A5A_A5A5);
    endtask

    // Minimum and maximum move only on strict changes; a cleared channel
    // takes its next sample as both.
    task automatic test_min_max_tracking;
        send_request(CMD_SAMPLE, 4'd1, 12'd2048, 32'd100);
        send_request(CMD_SAMPLE, 4'd1, 12'd0, 32'd0);
        send_request(CMD_SAMPLE, 4'd1, 12'hFFF, 32'hFFFF_FFFF);
        send_request(CMD_SAMPLE, 4'd1, 12'd2048, 32'd200);
        send_request(CMD_SAMPLE, 4'd1, 12'd0, 32'd300);
        send_request(CMD_SAMPLE, 4'd1, 12'hFFF, 32'd400);
        send_request(CMD_CLEAR, 4'd1, 12'd0, 32'd0);
        send_request(CMD_SAMPLE, 4'd1, 12'hFFF, 32'hAAAA_5555);
    endtask

    // Smallest, zero and largest windows, and a window set below the count.
    task automatic test_window_limits;
        write_window(16'd1);
        send_request(CMD_SAMPLE, 4'd2, 12'd10, 32'd1);
        send_request(CMD_SAMPLE, 4'd2, 12'd20, 32'd2);
        send_request(CMD_SAMPLE, 4'd2, 12'd30, 32'd3);
        write_window(16'd0);
        send_request(CMD_SAMPLE, 4'd3, 12'd100, 32'd4);
        send_request(CMD_SAMPLE, 4'd3, 12'd4000, 32'd5);
        write_window(16'hFFFF);
        send_request(CMD_SAMPLE, 4'd0, 12'hFFF, 32'd6);
        send_request(CMD_SAMPLE, 4'd0, 12'd0, 32'd7);
        send_request(CMD_SAMPLE, 4'd0, 12'hFFF, 32'd8);
        write_window(16'd2);
        send_request(CMD_SAMPLE, 4'd0, 12'd7, 32'd9);
        send_request(CMD_SAMPLE, 4'd0, 12'd3000, 32'd10);
    endtask

    task automatic test_random_traffic;
        logic [CNT_W-1:0]    w;
        logic [CHAN_W-1:0]   ch;
        logic [SAMPLE_W-1:0] smp;
        logic                cmd;
        int unsigned         pick;
        for (int p = 0; p < 12; p++) begin
            case (p)
                0:       w = 16'd16;
                1:       w = 16'd1;
                2:       w = 16'd0;
                3:       w = 16'hFFFF;
                4:       w = 16'd4;
                5:       w = 16'd2;
                6:       w = 16'd32;
                7:       w = 16'd7;
                8:       w = 16'd255;
                9:       w = 16'd3;
                10:      w = 16'd1000;
                default: w = CNT_W'($urandom_range(65535, 1));
            endcase
            write_window(w);
            // One phase runs with neither side idling.
            no_idle = (p == 5);
            repeat (150) begin
                if ($urandom_range(99) < 10) begin
                    ch = CHAN_W'($urandom_range(15, NUM_CHANNELS));
                end else begin
                    ch = CHAN_W'($urandom_range(NUM_CHANNELS - 1, 0));
                end
                cmd  = ($urandom_range(99) < 4) ? CMD_CLEAR : CMD_SAMPLE;
                pick = $urandom_range(99);
                if (pick < 15) begin
                    smp = SAMPLE_W'($urandom_range(7));
                end else if (pick < 30) begin
                    smp = 12'hFFF - SAMPLE_W'($urandom_range(7));
                end else begin
                    smp = SAMPLE_W'($urandom_range(4095));
                end
                send_request(cmd, ch, smp, $urandom);
            end
            no_idle = 1'b0;
        end
    endtask

    // The result side holds off long enough for the request queue to fill
    // and the input to stall.
    task automatic test_output_hold;
        no_idle = 1'b1;
        rx_hold_request = HOLD_CYCLES;
        repeat (20) begin
            send_request(CMD_SAMPLE, CHAN_W'($urandom_range(NUM_CHANNELS - 1, 0)),
                         SAMPLE_W'($urandom_range(4095)), $urandom);
        end
        no_idle = 1'b0;
        wait_drained();
    endtask

    // Each request waits until the previous result is out.
    task automatic test_paced_requests;
        repeat (12) begin
            send_request(($urandom_range(9) == 0) ? CMD_CLEAR : CMD_SAMPLE,
                         CHAN_W'($urandom_range(15, 0)),
                         SAMPLE_W'($urandom_range(4095)), $urandom);
            wait_drained();
        end
    endtask

    initial begin
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            clear_channel(c);
        end
        avg_window = WINDOW_RESET;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_empty_and_bad_channels();
        test_min_max_tracking();
        test_window_limits();
        test_random_traffic();
        test_output_hold();
        test_paced_requests();

        wait_drained();
        repeat (40) @(negedge i_clk);
        if (errors == 0) begin
            $display("channel_min_max_average_tracker test passed");
        end else begin
            $display("channel_min_max_average_tracker test failed");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("channel_min_max_average_tracker test failed");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/cmtr_pkg.sv
sv/cmtr_front.sv
sv/cmtr_fifo.sv
sv/cmtr_back.sv
sv/channel_min_max_average_tracker.sv
sv/cmtr_checker.sv
tb/sv/tb_channel_min_max_average_tracker.sv
